FILE: src/aabb_affine_transform_defines.svh
// assertion macros shared by the datapath modules
`ifndef AABB_AFFINE_TRANSFORM_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define AAT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aabb affine transform: same-cycle check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define AAT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aabb affine transform: next-cycle check failed");

`endif

FILE: src/aat_pkg.sv
package aat_pkg;

  // default field widths
  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned COEF_BITS_DEF  = 16;

  // register port geometry
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 6;

  // register indexes, one per 8-byte slot
  typedef enum logic [2:0] {
    REG_ROW0  = 3'd0,
    REG_ROW1  = 3'd1,
    REG_ROW2  = 3'd2,
    REG_OFF_X = 3'd3,
    REG_OFF_Y = 3'd4,
    REG_OFF_Z = 3'd5
  } reg_idx_e;

endpackage

FILE: src/aat_in_if.sv
interface aat_in_if import aat_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] base_x;
  logic signed [COORD_BITS-1:0] base_y;
  logic signed [COORD_BITS-1:0] base_z;
  logic        [COORD_BITS-2:0] side_x;
  logic        [COORD_BITS-2:0] side_y;
  logic        [COORD_BITS-2:0] side_z;

  modport source (output valid, base_x, base_y, base_z, side_x, side_y, side_z, input ready);
  modport sink   (input valid, base_x, base_y, base_z, side_x, side_y, side_z, output ready);
endinterface

FILE: src/aat_out_if.sv
interface aat_out_if import aat_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_base_x;
  logic signed [COORD_BITS-1:0] out_base_y;
  logic signed [COORD_BITS-1:0] out_base_z;
  logic        [COORD_BITS-2:0] out_side_x;
  logic        [COORD_BITS-2:0] out_side_y;
  logic        [COORD_BITS-2:0] out_side_z;

  modport source (output valid, out_base_x, out_base_y, out_base_z,
                  out_side_x, out_side_y, out_side_z, input ready);
  modport sink   (input valid, out_base_x, out_base_y, out_base_z,
                  out_side_x, out_side_y, out_side_z, output ready);
endinterface

FILE: src/aabb_affine_transform.sv
// channel  | dir | beat contents                         | handshake
// box_i    | in  | base_x/y/z, side_x/y/z                | valid, ready
// box_o    | out | out_base_x/y/z, out_side_x/y/z        | valid, ready
// register | in  | row0..row2 linear, offset_x/y/z       | apb write, pready high
//
// one box per cycle while box_o accepts it; each beat is registered in every stage
// the four register stages are products, row sums, edge sums, clamp
// each stage holds its beat while the next one is full, so stalls lose nothing
// reset clears the stage valid bits and loads identity matrix, zero offset
module aabb_affine_transform import aat_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned COEF_BITS  = COEF_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  aat_in_if.sink                box_i,
  aat_out_if.source             box_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned PROD_W = COORD_BITS + COEF_BITS;

  logic [8:0][COEF_BITS-1:0]   coef;
  logic [2:0][COORD_BITS-1:0]  offset;
  logic [2:0][COORD_BITS-1:0]  base_in;
  logic [2:0][COORD_BITS-2:0]  side_in;
  logic                        mul_valid, mul_ready;
  logic [8:0][PROD_W-1:0]      pb, ps;
  logic [8:0]                  neg;
  logic                        sum_valid, sum_ready;
  logic [2:0][COORD_BITS+6:0]  lo, hi;
  logic [2:0][COORD_BITS-1:0]  base_out;
  logic [2:0][COORD_BITS-2:0]  side_out;

  // register file
  aat_cfg #(
    .COORD_BITS (COORD_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .coef_o   (coef),
    .offset_o (offset)
  );

  // input beat as arrays
  assign base_in[0] = box_i.base_x;
  assign base_in[1] = box_i.base_y;
  assign base_in[2] = box_i.base_z;
  assign side_in[0] = box_i.side_x;
  assign side_in[1] = box_i.side_y;
  assign side_in[2] = box_i.side_z;

  aat_mul #(
    .COORD_BITS (COORD_BITS),
    .COEF_BITS  (COEF_BITS),
    .PROD_W     (PROD_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (box_i.valid),
    .ready_o (box_i.ready),
    .base_i  (base_in),
    .side_i  (side_in),
    .coef_i  (coef),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .pb_o    (pb),
    .ps_o    (ps),
    .neg_o   (neg)
  );

  aat_sum #(
    .COORD_BITS (COORD_BITS),
    .COEF_BITS  (COEF_BITS),
    .PROD_W     (PROD_W)
  ) u_sum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mul_valid),
    .ready_o  (mul_ready),
    .pb_i     (pb),
    .ps_i     (ps),
    .neg_i    (neg),
    .offset_i (offset),
    .valid_o  (sum_valid),
    .ready_i  (sum_ready),
    .lo_o     (lo),
    .hi_o     (hi)
  );

  aat_out #(
    .COORD_BITS (COORD_BITS)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .lo_i    (lo),
    .hi_i    (hi),
    .valid_o (box_o.valid),
    .ready_i (box_o.ready),
    .base_o  (base_out),
    .side_o  (side_out)
  );

  // result beat fields
  assign box_o.out_base_x = base_out[0];
  assign box_o.out_base_y = base_out[1];
  assign box_o.out_base_z = base_out[2];
  assign box_o.out_side_x = side_out[0];
  assign box_o.out_side_y = side_out[1];
  assign box_o.out_side_z = side_out[2];

endmodule

FILE: src/aat_cfg.sv
module aat_cfg import aat_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned COEF_BITS  = COEF_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [APB_ADDR_W-1:0]               paddr,
  input  logic [APB_DATA_W-1:0]               pwdata,
  output logic [APB_DATA_W-1:0]               prdata,
  output logic                                pready,
  output logic [8:0][COEF_BITS-1:0]           coef_o,
  output logic [2:0][COORD_BITS-1:0]          offset_o
);

  localparam int unsigned ROW_W = 3 * COEF_BITS;
  localparam int unsigned FRAC  = COEF_BITS - 4;

  logic [2:0][ROW_W-1:0]      row_d, row_q;
  logic [2:0][COORD_BITS-1:0] off_d, off_q;
  logic                       wr_en;
  reg_idx_e                   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:3]);

  // register write decode, out-of-range slots are dropped
  always_comb begin
    row_d = row_q;
    off_d = off_q;
    if (wr_en) begin
      unique case (idx)
        REG_ROW0:  row_d[0] = ROW_W'(pwdata);
        REG_ROW1:  row_d[1] = ROW_W'(pwdata);
        REG_ROW2:  row_d[2] = ROW_W'(pwdata);
        REG_OFF_X: off_d[0] = COORD_BITS'(pwdata);
        REG_OFF_Y: off_d[1] = COORD_BITS'(pwdata);
        REG_OFF_Z: off_d[2] = COORD_BITS'(pwdata);
        default: ;
      endcase
    end
  end

  // identity matrix and zero offset after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW_W'(1) << FRAC;
      row_q[1] <= ROW_W'(1) << (FRAC + COEF_BITS);
      row_q[2] <= ROW_W'(1) << (FRAC + 2 * COEF_BITS);
      off_q    <= '0;
    end else begin
      row_q <= row_d;
      off_q <= off_d;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_ROW0:  prdata = APB_DATA_W'(row_q[0]);
      REG_ROW1:  prdata = APB_DATA_W'(row_q[1]);
      REG_ROW2:  prdata = APB_DATA_W'(row_q[2]);
      REG_OFF_X: prdata = APB_DATA_W'(off_q[0]);
      REG_OFF_Y: prdata = APB_DATA_W'(off_q[1]);
      REG_OFF_Z: prdata = APB_DATA_W'(off_q[2]);
      default:   prdata = '0;
    endcase
  end

  // unpack coefficients, m[r][c] at index 3*r+c
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign coef_o[3*r+c] = row_q[r][c*COEF_BITS +: COEF_BITS];
    end
  end

  assign offset_o = off_q;

endmodule

FILE: src/aat_mul.sv
`include "aabb_affine_transform_defines.svh"

module aat_mul import aat_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned COEF_BITS  = COEF_BITS_DEF,
  parameter int unsigned PROD_W     = COORD_BITS + COEF_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [2:0][COORD_BITS-1:0] base_i,
  input  logic [2:0][COORD_BITS-2:0] side_i,
  input  logic [8:0][COEF_BITS-1:0]  coef_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [8:0][PROD_W-1:0]     pb_o,
  output logic [8:0][PROD_W-1:0]     ps_o,
  output logic [8:0]                 neg_o
);

  logic [8:0][PROD_W-1:0] pb_d, pb_q;
  logic [8:0][PROD_W-1:0] ps_d, ps_q;
  logic [8:0]             neg_d, neg_q;
  logic                   valid_q;
  logic                   load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // nine coefficient products with the base and nine with the side
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign pb_d[3*r+c]  = $signed(coef_i[3*r+c]) * $signed(base_i[c]);
      assign ps_d[3*r+c]  = $signed(coef_i[3*r+c]) * $signed({1'b0, side_i[c]});
      assign neg_d[3*r+c] = coef_i[3*r+c][COEF_BITS-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pb_q  <= pb_d;
      ps_q  <= ps_d;
      neg_q <= neg_d;
    end
  end

  assign valid_o = valid_q;
  assign pb_o    = pb_q;
  assign ps_o    = ps_q;
  assign neg_o   = neg_q;

  // a held product beat stays valid until taken
  `AAT_ASSERT_NXT(mul_hold_a, valid_q && !ready_i, valid_q)

endmodule

FILE: src/aat_sum.sv
`include "aabb_affine_transform_defines.svh"

module aat_sum import aat_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned COEF_BITS  = COEF_BITS_DEF,
  parameter int unsigned PROD_W     = COORD_BITS + COEF_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [8:0][PROD_W-1:0]                 pb_i,
  input  logic [8:0][PROD_W-1:0]                 ps_i,
  input  logic [8:0]                             neg_i,
  input  logic [2:0][COORD_BITS-1:0]             offset_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [2:0][COORD_BITS+6:0]             lo_o,
  output logic [2:0][COORD_BITS+6:0]             hi_o
);

  localparam int unsigned FRAC  = COEF_BITS - 4;
  localparam int unsigned SUM_W = PROD_W + 2;
  localparam int unsigned ACC_W = PROD_W + 3;
  localparam int unsigned EXT_W = ACC_W - COORD_BITS - FRAC;

  logic [2:0][SUM_W-1:0] ba_d, ba_q, sn_d, sn_q, sp_d, sp_q;
  logic [2:0][ACC_W-1:0] off_ext, lo_d, lo_q, hi_d, hi_q;
  logic                  a_valid_q, b_valid_q;
  logic                  a_ready, b_ready;

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  // first stage: base row sum, side terms split by coefficient sign
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ba_d[r] = '0;
      sn_d[r] = '0;
      sp_d[r] = '0;
      for (int c = 0; c < 3; c++) begin
        ba_d[r] = ba_d[r] + SUM_W'($signed(pb_i[3*r+c]));
        if (neg_i[3*r+c]) begin
          sn_d[r] = sn_d[r] + SUM_W'($signed(ps_i[3*r+c]));
        end else begin
          sp_d[r] = sp_d[r] + SUM_W'($signed(ps_i[3*r+c]));
        end
      end
    end
  end

  // second stage: offset lifted to the product scale, then low and high edges
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      off_ext[r] = {{EXT_W{offset_i[r][COORD_BITS-1]}}, offset_i[r], {FRAC{1'b0}}};
      lo_d[r]    = off_ext[r] + ACC_W'($signed(ba_q[r])) + ACC_W'($signed(sn_q[r]));
      hi_d[r]    = off_ext[r] + ACC_W'($signed(ba_q[r])) + ACC_W'($signed(sp_q[r]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && a_ready) begin
      ba_q <= ba_d;
      sn_q <= sn_d;
      sp_q <= sp_d;
    end
    if (a_valid_q && b_ready) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // floor to signed coordinate units, COORD_BITS+7 bits wide, by dropping the Q4.12 coefficient fraction bits
  for (genvar r = 0; r < 3; r++) begin : g_axis
    assign lo_o[r] = lo_q[r][ACC_W-1:FRAC];
    assign hi_o[r] = hi_q[r][ACC_W-1:FRAC];
  end

  assign valid_o = b_valid_q;

  // partial sums are not dropped while the edge stage is stalled
  `AAT_ASSERT_NXT(sum_hold_a, a_valid_q && !b_ready, a_valid_q)
  // the high edge never lies below the low edge
  `AAT_ASSERT(sum_order_a, b_valid_q, ($signed(hi_q[0]) >= $signed(lo_q[0])) && ($signed(hi_q[1]) >= $signed(lo_q[1])) && ($signed(hi_q[2]) >= $signed(lo_q[2])))

endmodule

FILE: src/aat_out.sv
`include "aabb_affine_transform_defines.svh"

module aat_out import aat_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [2:0][COORD_BITS+6:0] lo_i,
  input  logic [2:0][COORD_BITS+6:0] hi_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [2:0][COORD_BITS-1:0] base_o,
  output logic [2:0][COORD_BITS-2:0] side_o
);

  localparam int unsigned FLR_W  = COORD_BITS + 7;
  localparam int unsigned DIFF_W = FLR_W + 1;

  logic [2:0][DIFF_W-1:0]     diff;
  logic [2:0]                 diff_neg;
  logic [2:0][COORD_BITS-1:0] base_d, base_q;
  logic [2:0][COORD_BITS-2:0] side_d, side_q;
  logic                       valid_q;
  logic                       load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // clamp base to the coordinate range, side to the unsigned field
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if ((&lo_i[r][FLR_W-1:COORD_BITS-1]) || !(|lo_i[r][FLR_W-1:COORD_BITS-1])) begin
        base_d[r] = lo_i[r][COORD_BITS-1:0];
      end else if (lo_i[r][FLR_W-1]) begin
        base_d[r] = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
        base_d[r] = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      diff[r]     = DIFF_W'($signed(hi_i[r])) - DIFF_W'($signed(lo_i[r]));
      diff_neg[r] = diff[r][DIFF_W-1];
      if (diff_neg[r]) begin
        side_d[r] = '0;
      end else if (|diff[r][DIFF_W-2:COORD_BITS-1]) begin
        side_d[r] = '1;
      end else begin
        side_d[r] = diff[r][COORD_BITS-2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      base_q <= base_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign base_o  = base_q;
  assign side_o  = side_q;

  // extent is never negative on a loaded beat
  `AAT_ASSERT(out_extent_a, load, !(|diff_neg))

endmodule
